// ===== rtl/core/stb_pkg.sv =====
// Shared types, token codes and character tables for the source byte tokenizer.
// No dependencies; used by every module of the block.
package stb_pkg;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_IDENT  = 2'd1,
        CLS_NUMBER = 2'd2,
        CLS_HELD   = 2'd3
    } cls_t;

    typedef enum logic [5:0] {
        K_COLCOL = 6'd0,  K_EQEQ   = 6'd1,  K_EQ     = 6'd2,  K_NE     = 6'd3,
        K_BANG   = 6'd4,  K_PLUSEQ = 6'd5,  K_INC    = 6'd6,  K_PLUS   = 6'd7,
        K_DEC    = 6'd8,  K_MINUSEQ= 6'd9,  K_MINUS  = 6'd10, K_MULEQ  = 6'd11,
        K_MUL    = 6'd12, K_DIVEQ  = 6'd13, K_DIV    = 6'd14, K_MODEQ  = 6'd15,
        K_MOD    = 6'd16, K_SHL    = 6'd17, K_LE     = 6'd18, K_LT     = 6'd19,
        K_SHR    = 6'd20, K_GE     = 6'd21, K_GT     = 6'd22, K_TILDE  = 6'd23,
        K_OROR   = 6'd24, K_OR     = 6'd25, K_ANDAND = 6'd26, K_AND    = 6'd27,
        K_XOR    = 6'd28, K_LBRACE = 6'd29, K_RBRACE = 6'd30, K_LBRACK = 6'd31,
        K_RBRACK = 6'd32, K_LPAREN = 6'd33, K_RPAREN = 6'd34, K_SEMI   = 6'd35,
        K_DOT    = 6'd36, K_COMMA  = 6'd37, K_KEYWORD0 = 6'd38,
        K_IDENT  = 6'd50, K_INT    = 6'd51, K_FLOAT  = 6'd52, K_INVALID = 6'd53,
        K_END    = 6'd54
    } tok_kind_t;

    localparam logic [5:0] NO_KIND = 6'h3F;
    localparam int FIELD_BITS = 20;
    localparam int KW_COUNT = 12;
    localparam int KW_CHARS = 9;

    // Keyword text, right aligned: character j of a keyword of length n sits
    // at bits [8*(n-1-j) +: 8].
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "proc", "interface", "mut", "const", "impl", "void",
        "int", "float", "bool", "byte", "true", "false"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd9, 4'd3, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5, 4'd4, 4'd4, 4'd4, 4'd5
    };

    typedef struct packed {
        logic [5:0]            kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] len;
        logic [FIELD_BITS-1:0] line;
        logic                  last;
    } tok_res_t;

    function automatic logic is_alpha(input logic [7:0] b);
        logic [7:0] l;
        l = b | 8'h20;
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // Kind of a held operator byte standing alone, NO_KIND if not holdable.
    function automatic logic [5:0] held_single(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h3A:   k = K_INVALID; // lone colon
            8'h3D:   k = K_EQ;
            8'h21:   k = K_BANG;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_MUL;
            8'h2F:   k = K_DIV;
            8'h25:   k = K_MOD;
            8'h3C:   k = K_LT;
            8'h3E:   k = K_GT;
            8'h7C:   k = K_OR;
            8'h26:   k = K_AND;
            default: k = NO_KIND;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] b);
        logic [5:0] k;
        k = NO_KIND;
        if (b == 8'h3D) begin
            case (h)
                8'h3D:   k = K_EQEQ;
                8'h21:   k = K_NE;
                8'h2B:   k = K_PLUSEQ;
                8'h2D:   k = K_MINUSEQ;
                8'h2A:   k = K_MULEQ;
                8'h2F:   k = K_DIVEQ;
                8'h25:   k = K_MODEQ;
                8'h3C:   k = K_LE;
                8'h3E:   k = K_GE;
                default: k = NO_KIND;
            endcase
        end else if (b == h) begin
            case (h)
                8'h3A:   k = K_COLCOL;
                8'h2B:   k = K_INC;
                8'h2D:   k = K_DEC;
                8'h3C:   k = K_SHL;
                8'h3E:   k = K_SHR;
                8'h7C:   k = K_OROR;
                8'h26:   k = K_ANDAND;
                default: k = NO_KIND;
            endcase
        end
        return k;
    endfunction

    function automatic logic [5:0] plain_single(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h7E:   k = K_TILDE;
            8'h5E:   k = K_XOR;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h3B:   k = K_SEMI;
            8'h2E:   k = K_DOT;
            8'h2C:   k = K_COMMA;
            default: k = K_INVALID;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/source_byte_tokenizer.sv =====
// Top level of the source byte tokenizer: line number register, lexer core
// and result queue. Depends on stb_pkg, stb_lexer_core, stb_result_queue.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, source_byte, end_of_input | request in
//  out     | out_valid, out_ready, token_kind .. last_of_run | request out
//  cfg     | first_line_we, first_line_number           | write only
//
// One byte request is taken per cycle while in_ready is high; the lexer step
// is a single pass of logic from the lexer state registers into the result
// queue. A byte yields zero, one or two tokens; the queue hands out one token
// per cycle while out_ready is high, so a burst of two-token bytes fills it.
// in_ready drops only while the queue holds three or four tokens.
// Reset clears the lexer and queue at once; the line count restarts at 1.
module source_byte_tokenizer #(
    parameter int OFFSET_BITS        = 20,
    parameter int KEYWORD_MAX_LENGTH = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  source_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [19:0] start_offset,
    output logic [19:0] token_length,
    output logic [19:0] line_number,
    output logic        last_of_run,
    input  logic        first_line_we,
    input  logic [19:0] first_line_number
);

    logic [19:0]       first_line_reg;
    logic              step;
    stb_pkg::tok_res_t res0, res1, head;
    logic [1:0]        res_count;
    logic              room_for_two;
    logic [2:0]        fill;

    // Hold the line number that a new source starts at.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_line_reg <= 20'd1;
        else if (first_line_we)
            first_line_reg <= first_line_number;
    end

    // Advance the lexer whenever a byte request is taken.
    assign in_ready = room_for_two;
    assign step     = in_valid && room_for_two;

    stb_lexer_core #(
        .OFFSET_BITS        (OFFSET_BITS),
        .KEYWORD_MAX_LENGTH (KEYWORD_MAX_LENGTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .source_byte  (source_byte),
        .end_of_input (end_of_input),
        .first_line   (first_line_reg),
        .cfg_load     (first_line_we),
        .cfg_data     (first_line_number),
        .res0         (res0),
        .res1         (res1),
        .res_count    (res_count)
    );

    stb_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .res0         (res0),
        .res1         (res1),
        .push_count   (res_count),
        .pop          (out_ready),
        .head         (head),
        .not_empty    (out_valid),
        .room_for_two (room_for_two),
        .fill         (fill)
    );

    assign token_kind   = head.kind;
    assign start_offset = head.start;
    assign token_length = head.len;
    assign line_number  = head.line;
    assign last_of_run  = head.last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= 3'd4)
        else $error("result queue overfilled");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == stb_pkg::K_END |-> last_of_run)
        else $error("end token not marked last");

    a_end_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_input |=> out_valid)
        else $error("end of input gave no token");
`endif

endmodule

// ===== rtl/core/stb_lexer_core.sv =====
// Lexer state and single-pass step logic: one accepted byte updates the state
// and yields zero to two tokens. Depends on stb_pkg.
module stb_lexer_core #(
    parameter int OFFSET_BITS        = 20,
    parameter int KEYWORD_MAX_LENGTH = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [7:0]                      source_byte,
    input  logic                            end_of_input,
    input  logic [stb_pkg::FIELD_BITS-1:0]  first_line,
    input  logic                            cfg_load,
    input  logic [stb_pkg::FIELD_BITS-1:0]  cfg_data,
    output stb_pkg::tok_res_t               res0,
    output stb_pkg::tok_res_t               res1,
    output logic [1:0]                      res_count
);

    localparam int IDXW = $clog2(KEYWORD_MAX_LENGTH);
    localparam int WIDE = (OFFSET_BITS > stb_pkg::FIELD_BITS) ? OFFSET_BITS
                                                              : stb_pkg::FIELD_BITS;
    localparam logic [OFFSET_BITS-1:0] KMAX = OFFSET_BITS'(KEYWORD_MAX_LENGTH);

    stb_pkg::cls_t            cls_reg, cls_next;
    logic [7:0]               held_reg, held_next;
    logic [OFFSET_BITS-1:0]   offs_reg, offs_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [OFFSET_BITS-1:0]   len_reg, len_next;
    logic [stb_pkg::FIELD_BITS-1:0] line_reg, line_next;
    logic                     dot_reg, dot_next;
    logic                     broken_reg, broken_next;
    logic [7:0]               cand_reg [KEYWORD_MAX_LENGTH];
    logic                     cand_we;
    logic [IDXW-1:0]          cand_idx;

    logic [5:0]               open_kind;
    logic [5:0]               pk, hk;
    logic                     ident_ch;
    logic                     num_ch;

    function automatic logic [stb_pkg::FIELD_BITS-1:0] to_field(
        input logic [OFFSET_BITS-1:0] x);
        logic [WIDE-1:0] t;
        t = WIDE'(x);
        return t[stb_pkg::FIELD_BITS-1:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    // Parallel keyword compare on candidate bytes, or the open number's kind.
    always_comb
    begin
        logic match;
        open_kind = stb_pkg::K_IDENT;
        for (int i = stb_pkg::KW_COUNT - 1; i >= 0; i--)
        begin
            match = (len_reg == OFFSET_BITS'(stb_pkg::KW_LEN[i]));
            for (int j = 0; j < stb_pkg::KW_CHARS; j++)
            begin
                if (j < int'(stb_pkg::KW_LEN[i]) &&
                    cand_reg[j] != stb_pkg::KW_TEXT[i][8*(int'(stb_pkg::KW_LEN[i])-1-j) +: 8])
                    match = 1'b0;
            end
            if (match)
                open_kind = 6'(stb_pkg::K_KEYWORD0 + i);
        end
        if (cls_reg == stb_pkg::CLS_NUMBER)
            open_kind = broken_reg ? stb_pkg::K_INVALID
                                   : (dot_reg ? stb_pkg::K_FLOAT : stb_pkg::K_INT);
    end

    assign pk       = stb_pkg::pair_kind(held_reg, source_byte);
    assign hk       = stb_pkg::held_single(held_reg);
    assign ident_ch = stb_pkg::is_alpha(source_byte) || stb_pkg::is_digit(source_byte) ||
                      (source_byte == 8'h5F);
    assign num_ch   = stb_pkg::is_digit(source_byte) || (source_byte == 8'h2E);

    always_comb
    begin
        logic fall;
        stb_pkg::tok_res_t fl;
        logic fl_v;
        stb_pkg::tok_res_t nw;
        logic nw_v;

        cls_next    = cls_reg;
        held_next   = held_reg;
        offs_next   = offs_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        line_next   = line_reg;
        dot_next    = dot_reg;
        broken_next = broken_reg;
        cand_we     = 1'b0;
        cand_idx    = len_reg[IDXW-1:0];
        fall        = 1'b0;

        // Flush of the open or held token.
        fl.kind  = (cls_reg == stb_pkg::CLS_HELD) ? hk : open_kind;
        fl.start = to_field(start_reg);
        fl.len   = (cls_reg == stb_pkg::CLS_HELD) ? stb_pkg::FIELD_BITS'(1)
                                                  : to_field(len_reg);
        fl.line  = line_reg;
        fl.last  = 1'b0;
        fl_v     = 1'b0;
        nw       = fl;
        nw_v     = 1'b0;

        if (end_of_input || source_byte == 8'h00)
        begin
            fl_v       = (cls_reg != stb_pkg::CLS_NONE);
            nw.kind    = stb_pkg::K_END;
            nw.start   = to_field(offs_reg);
            nw.len     = '0;
            nw.line    = line_reg;
            nw_v       = 1'b1;
            cls_next   = stb_pkg::CLS_NONE;
            held_next  = '0;
            offs_next  = '0;
            start_next = '0;
            len_next   = '0;
            line_next  = first_line;
            dot_next   = 1'b0;
            broken_next = 1'b0;
        end
        else
        begin
            case (cls_reg)
                stb_pkg::CLS_HELD:
                begin
                    if (pk != stb_pkg::NO_KIND)
                    begin
                        nw.kind   = pk;
                        nw.len    = stb_pkg::FIELD_BITS'(2);
                        nw_v      = 1'b1;
                        cls_next  = stb_pkg::CLS_NONE;
                        held_next = '0;
                        offs_next = sat_inc(offs_reg);
                    end
                    else
                    begin
                        fl_v = 1'b1;
                        fall = 1'b1;
                    end
                end
                stb_pkg::CLS_IDENT:
                begin
                    if (ident_ch)
                    begin
                        cand_we   = (len_reg < KMAX);
                        len_next  = sat_inc(len_reg);
                        offs_next = sat_inc(offs_reg);
                    end
                    else
                    begin
                        fl_v = 1'b1;
                        fall = 1'b1;
                    end
                end
                stb_pkg::CLS_NUMBER:
                begin
                    if (num_ch)
                    begin
                        if (source_byte == 8'h2E)
                        begin
                            broken_next = broken_reg | dot_reg;
                            dot_next    = 1'b1;
                        end
                        len_next  = sat_inc(len_reg);
                        offs_next = sat_inc(offs_reg);
                    end
                    else
                    begin
                        fl_v = 1'b1;
                        fall = 1'b1;
                    end
                end
                default:
                    fall = 1'b1;
            endcase

            if (fall)
            begin
                cls_next  = stb_pkg::CLS_NONE;
                held_next = '0;
                offs_next = sat_inc(offs_reg);
                if (source_byte inside {8'h20, 8'h09, 8'h0D, 8'h0A})
                begin
                    if (source_byte == 8'h0A && !(&line_reg))
                        line_next = line_reg + 1'b1;
                end
                else if (stb_pkg::is_alpha(source_byte))
                begin
                    cls_next   = stb_pkg::CLS_IDENT;
                    start_next = offs_reg;
                    len_next   = OFFSET_BITS'(1);
                    cand_we    = 1'b1;
                    cand_idx   = '0;
                end
                else if (stb_pkg::is_digit(source_byte))
                begin
                    cls_next    = stb_pkg::CLS_NUMBER;
                    start_next  = offs_reg;
                    len_next    = OFFSET_BITS'(1);
                    dot_next    = 1'b0;
                    broken_next = 1'b0;
                end
                else if (stb_pkg::held_single(source_byte) != stb_pkg::NO_KIND)
                begin
                    cls_next   = stb_pkg::CLS_HELD;
                    held_next  = source_byte;
                    start_next = offs_reg;
                    len_next   = OFFSET_BITS'(1);
                end
                else
                begin
                    nw.kind  = stb_pkg::plain_single(source_byte);
                    nw.start = to_field(offs_reg);
                    nw.len   = stb_pkg::FIELD_BITS'(1);
                    nw.line  = line_reg;
                    nw_v     = 1'b1;
                end
            end
        end

        // Pack the results in order and mark the final one.
        if (fl_v && nw_v)
        begin
            res0      = fl;
            res1      = nw;
            res1.last = 1'b1;
            res_count = 2'd2;
        end
        else if (fl_v || nw_v)
        begin
            res0      = fl_v ? fl : nw;
            res0.last = 1'b1;
            res1      = nw;
            res_count = 2'd1;
        end
        else
        begin
            res0      = fl;
            res1      = nw;
            res_count = 2'd0;
        end
        if (!step)
            res_count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg    <= stb_pkg::CLS_NONE;
            held_reg   <= '0;
            offs_reg   <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            line_reg   <= stb_pkg::FIELD_BITS'(1);
            dot_reg    <= 1'b0;
            broken_reg <= 1'b0;
        end
        else if (step)
        begin
            cls_reg    <= cls_next;
            held_reg   <= held_next;
            offs_reg   <= offs_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            line_reg   <= line_next;
            dot_reg    <= dot_next;
            broken_reg <= broken_next;
        end
        else if (cfg_load && offs_reg == '0 && cls_reg == stb_pkg::CLS_NONE)
        begin
            line_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && cand_we)
            cand_reg[cand_idx] <= source_byte;
    end

endmodule

// ===== rtl/core/stb_result_queue.sv =====
// Four-entry result queue: takes up to two tokens a cycle, hands out one.
// Depends on stb_pkg.
module stb_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  stb_pkg::tok_res_t res0,
    input  stb_pkg::tok_res_t res1,
    input  logic [1:0]        push_count,
    input  logic              pop,
    output stb_pkg::tok_res_t head,
    output logic              not_empty,
    output logic              room_for_two,
    output logic [2:0]        fill
);

    stb_pkg::tok_res_t mem_reg [4];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] fill_reg, fill_next;
    logic       do_pop;

    assign do_pop       = pop && (fill_reg != 3'd0);
    assign head         = mem_reg[rd_reg];
    assign not_empty    = (fill_reg != 3'd0);
    assign room_for_two = (fill_reg <= 3'd2);
    assign fill         = fill_reg;

    always_comb
    begin
        rd_next   = rd_reg + 2'(do_pop);
        wr_next   = wr_reg + push_count;
        fill_next = fill_reg + 3'(push_count) - 3'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            rd_reg   <= rd_next;
            wr_reg   <= wr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_reg] <= res0;
        if (push_count == 2'd2)
            mem_reg[wr_reg + 2'd1] <= res1;
    end

endmodule

// ===== tb/sv/tb_source_byte_tokenizer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for source_byte_tokenizer: byte requests in, token requests out.
// Depends on stb_pkg and source_byte_tokenizer; carries its own lexer predictor.
module tb_source_byte_tokenizer;
    import stb_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
    } src_req_t;

    // Saturation limits of the offset and line counters.
    localparam logic [19:0] SAT20 = 20'hFFFFF;
    localparam int KW_MAX = 9;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  source_byte;
    logic        end_of_input;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_kind;
    logic [19:0] start_offset;
    logic [19:0] token_length;
    logic [19:0] line_number;
    logic        last_of_run;
    logic        first_line_we;
    logic [19:0] first_line_number;

    source_byte_tokenizer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .source_byte       (source_byte),
        .end_of_input      (end_of_input),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .token_kind        (token_kind),
        .start_offset      (start_offset),
        .token_length      (token_length),
        .line_number       (line_number),
        .last_of_run       (last_of_run),
        .first_line_we     (first_line_we),
        .first_line_number (first_line_number)
    );

    // Byte requests waiting to be driven and tokens waiting to come out.
    src_req_t src_byte_q[$];
    tok_res_t token_expect_q[$];
    int       error_count;

    // Lexer state as the predictor sees it.
    cls_t        lx_class;
    logic [7:0]  lx_held;
    logic [19:0] lx_offset;
    logic [19:0] lx_start;
    logic [19:0] lx_length;
    logic [19:0] lx_line;
    logic [19:0] lx_first_line;
    logic [7:0]  lx_word [KW_MAX];
    logic        lx_dot;
    logic        lx_broken;

    string keyword_list [12] = '{"proc", "interface", "mut", "const", "impl", "void",
                                 "int", "float", "bool", "byte", "true", "false"};

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor: classify bytes and advance the lexer state.
    // ---------------------------------------------------------------
    function automatic logic letter_byte(logic [7:0] b);
        return ((b | 8'h20) >= "a") && ((b | 8'h20) <= "z");
    endfunction

    function automatic logic digit_byte(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    // Operator byte that may pair with the next one; NO_KIND when it may not.
    function automatic logic [5:0] lone_op_kind(logic [7:0] b);
        case (b)
            ":": return K_INVALID;
            "=": return K_EQ;
            "!": return K_BANG;
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_MUL;
            "/": return K_DIV;
            "%": return K_MOD;
            "<": return K_LT;
            ">": return K_GT;
            "|": return K_OR;
            "&": return K_AND;
            default: return NO_KIND;
        endcase
    endfunction

    function automatic logic [5:0] op_pair_kind(logic [7:0] h, logic [7:0] b);
        if (b == "=")
        begin
            case (h)
                "=": return K_EQEQ;
                "!": return K_NE;
                "+": return K_PLUSEQ;
                "-": return K_MINUSEQ;
                "*": return K_MULEQ;
                "/": return K_DIVEQ;
                "%": return K_MODEQ;
                "<": return K_LE;
                ">": return K_GE;
                default: return NO_KIND;
            endcase
        end
        if (b != h)
            return NO_KIND;
        case (h)
            ":": return K_COLCOL;
            "+": return K_INC;
            "-": return K_DEC;
            "<": return K_SHL;
            ">": return K_SHR;
            "|": return K_OROR;
            "&": return K_ANDAND;
            default: return NO_KIND;
        endcase
    endfunction

    // Single-byte punctuation; anything unlisted is an invalid token.
    function automatic logic [5:0] punct_kind(logic [7:0] b);
        case (b)
            "~": return K_TILDE;
            "^": return K_XOR;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            ";": return K_SEMI;
            ".": return K_DOT;
            ",": return K_COMMA;
            default: return K_INVALID;
        endcase
    endfunction

    function automatic logic [19:0] sat_next(logic [19:0] v);
        return (v == SAT20) ? v : v + 20'd1;
    endfunction

    // Kind of the identifier or number that is open now.
    function automatic logic [5:0] open_word_kind();
        string s;
        if (lx_class == CLS_NUMBER)
            return lx_broken ? K_INVALID : (lx_dot ? K_FLOAT : K_INT);
        if (lx_length > KW_MAX)
            return K_IDENT;
        s = "";
        for (int i = 0; i < lx_length; i++)
            s = {s, string'(lx_word[i])};
        for (int i = 0; i < 12; i++)
            if (s == keyword_list[i])
                return 6'(K_KEYWORD0 + i);
        return K_IDENT;
    endfunction

    task automatic add_token(logic [5:0] kind, logic [19:0] start, logic [19:0] len);
        tok_res_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.line  = lx_line;
        t.last  = 1'b0;
        token_expect_q.insert(token_expect_q.size(), t);
    endtask

    // Close the open identifier, number or held operator, if any.
    task automatic close_open_token();
        if (lx_class == CLS_HELD)
            add_token(lone_op_kind(lx_held), lx_start, 20'd1);
        else if (lx_class != CLS_NONE)
            add_token(open_word_kind(), lx_start, lx_length);
        lx_class = CLS_NONE;
        lx_held  = 8'd0;
    endtask

    task automatic restart_source();
        lx_class  = CLS_NONE;
        lx_held   = 8'd0;
        lx_offset = '0;
        lx_start  = '0;
        lx_length = '0;
        lx_line   = lx_first_line;
        lx_dot    = 1'b0;
        lx_broken = 1'b0;
    endtask

    // Work out the tokens caused by one accepted byte request.
    task automatic tokenize_byte(logic [7:0] b, logic eoi);
        int         n_before;
        logic [5:0] k;
        logic       consumed;
        n_before = token_expect_q.size();
        consumed = 1'b0;
        if (eoi || b == 8'd0)
        begin
            close_open_token();
            add_token(K_END, lx_offset, 20'd0);
            restart_source();
        end
        else
        begin
            if (lx_class == CLS_HELD)
            begin
                k = op_pair_kind(lx_held, b);
                if (k != NO_KIND)
                begin
                    add_token(k, lx_start, 20'd2);
                    lx_class  = CLS_NONE;
                    lx_held   = 8'd0;
                    lx_offset = sat_next(lx_offset);
                    consumed  = 1'b1;
                end
                else
                    close_open_token();
            end
            else if (lx_class == CLS_IDENT)
            begin
                if (letter_byte(b) || digit_byte(b) || b == "_")
                begin
                    if (lx_length < KW_MAX)
                        lx_word[lx_length[3:0]] = b;
                    lx_length = sat_next(lx_length);
                    lx_offset = sat_next(lx_offset);
                    consumed  = 1'b1;
                end
                else
                    close_open_token();
            end
            else if (lx_class == CLS_NUMBER)
            begin
                if (digit_byte(b) || b == ".")
                begin
                    if (b == ".")
                    begin
                        if (lx_dot)
                            lx_broken = 1'b1;
                        lx_dot = 1'b1;
                    end
                    lx_length = sat_next(lx_length);
                    lx_offset = sat_next(lx_offset);
                    consumed  = 1'b1;
                end
                else
                    close_open_token();
            end
            if (!consumed)
            begin
                if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A)
                begin
                    if (b == 8'h0A && lx_line != SAT20)
                        lx_line = lx_line + 20'd1;
                end
                else if (letter_byte(b))
                begin
                    lx_class  = CLS_IDENT;
                    lx_start  = lx_offset;
                    lx_length = 20'd1;
                    lx_word[0] = b;
                end
                else if (digit_byte(b))
                begin
                    lx_class  = CLS_NUMBER;
                    lx_start  = lx_offset;
                    lx_length = 20'd1;
                    lx_dot    = 1'b0;
                    lx_broken = 1'b0;
                end
                else if (lone_op_kind(b) != NO_KIND)
                begin
                    lx_class  = CLS_HELD;
                    lx_held   = b;
                    lx_start  = lx_offset;
                    lx_length = 20'd1;
                end
                else
                    add_token(punct_kind(b), lx_offset, 20'd1);
                lx_offset = sat_next(lx_offset);
            end
        end
        if (token_expect_q.size() > n_before)
            token_expect_q[token_expect_q.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string field, logic [19:0] got, logic [19:0] want);
        $display("%0t: token %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Monitor: predict on each accepted byte request, compare each token request.
    logic byte_taken;
    always @(posedge clk)
    begin
        tok_res_t want;
        if (rst_n && in_valid && in_ready)
        begin
            tokenize_byte(source_byte, end_of_input);
            byte_taken = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (token_expect_q.size() == 0)
                report_mismatch("count (extra token)", 20'd1, 20'd0);
            else
            begin
                want = token_expect_q.pop_front();
                if (token_kind !== want.kind)
                    report_mismatch("kind", 20'(token_kind), 20'(want.kind));
                if (start_offset !== want.start)
                    report_mismatch("start_offset", start_offset, want.start);
                if (token_length !== want.len)
                    report_mismatch("token_length", token_length, want.len);
                if (line_number !== want.line)
                    report_mismatch("line_number", line_number, want.line);
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", 20'(last_of_run), 20'(want.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver: bursts of byte requests separated by random gaps.
    // ---------------------------------------------------------------
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        src_req_t r;
        logic     next_valid;
        next_valid = in_valid;
        if (byte_taken || !in_valid)
        begin
            byte_taken = 1'b0;
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (src_byte_q.size() > 0)
            begin
                r = src_byte_q.pop_front();
                source_byte  <= r.data;
                end_of_input <= r.eoi;
                next_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    // Half the bursts, at random, are followed by no gap at all.
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid <= next_valid;
    end

    // Receiver: stall pattern is redrawn periodically from stall_tick; long hold-offs on request.
    int holds_asked;
    int holds_done;
    int hold_left;
    int stall_mode;
    int stall_tick;
    always @(negedge clk)
    begin
        if (stall_tick % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_tick++;
        if (holds_done < holds_asked)
        begin
            holds_done++;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= (stall_tick % 4 == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_text(string s);
        src_req_t r;
        for (int i = 0; i < s.len(); i++)
        begin
            r.data = s[i];
            r.eoi  = 1'b0;
            src_byte_q.insert(src_byte_q.size(), r);
        end
    endtask

    task automatic queue_byte(logic [7:0] b, logic eoi);
        src_req_t r;
        r.data = b;
        r.eoi  = eoi;
        src_byte_q.insert(src_byte_q.size(), r);
    endtask

    // One random lexeme; mostly well formed, some noise and ends of source.
    task automatic queue_random_lexeme();
        string ops;
        string s;
        int    n;
        int    p;
        ops = "::==!=+=++---=*=/=%=<<<=>>>=||&&";
        s = "";
        case ($urandom_range(0, 19))
            0, 1, 2: s = keyword_list[$urandom_range(0, 11)];
            3, 4, 5:
            begin
                n = $urandom_range(1, 13);
                s = {s, string'(8'($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25)))};
                for (int i = 1; i < n; i++)
                    case ($urandom_range(0, 3))
                        0:       s = {s, string'(8'("0") + 8'($urandom_range(0, 9)))};
                        1:       s = {s, "_"};
                        2:       s = {s, string'(8'("A") + 8'($urandom_range(0, 25)))};
                        default: s = {s, string'(8'("a") + 8'($urandom_range(0, 25)))};
                    endcase
            end
            6, 7:
            begin
                n = $urandom_range(1, 8);
                s = {s, string'(8'("0") + 8'($urandom_range(0, 9)))};
                for (int i = 1; i < n; i++)
                    s = {s, ($urandom_range(0, 4) == 0) ? "."
                            : string'(8'("0") + 8'($urandom_range(0, 9)))};
            end
            8, 9, 10:
            begin
                p = $urandom_range(0, 15);
                s = ops.substr(2 * p, 2 * p + 1);
            end
            11, 12:
            begin
                s = ":=!+-*/%<>|&~^{}[]();.,_";
                p = $urandom_range(0, s.len() - 1);
                s = s.substr(p, p);
            end
            13, 14: s = ($urandom_range(0, 2) == 0) ? "\t" : (($urandom_range(0, 1)) ? "\r" : " ");
            15, 16: s = "\n";
            17:
            begin
                queue_byte(8'($urandom_range(1, 255)), 1'b0);
                return;
            end
            18:
            begin
                if ($urandom_range(0, 2) == 0)
                    queue_byte($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                return;
            end
            default: s = " ";
        endcase
        queue_text(s);
        if ($urandom_range(0, 2) != 0)
            queue_text(" ");
    endtask

    // Wait until no byte request is pending and no token is still expected.
    task automatic wait_idle();
        while (src_byte_q.size() > 0 || in_valid || token_expect_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_first_line(logic [19:0] v);
        @(negedge clk);
        first_line_we     <= 1'b1;
        first_line_number <= v;
        @(negedge clk);
        first_line_we <= 1'b0;
        lx_first_line = v;
        if (lx_offset == '0 && lx_class == CLS_NONE)
            lx_line = v;
    endtask

    initial
    begin
        logic [19:0] line_setting [5];
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        source_byte   = 8'd0;
        end_of_input  = 1'b0;
        out_ready     = 1'b0;
        first_line_we = 1'b0;
        first_line_number = 20'd0;
        byte_taken    = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        holds_asked   = 0;
        holds_done    = 0;
        hold_left     = 0;
        stall_mode    = 0;
        stall_tick    = 0;
        error_count   = 0;
        lx_first_line = 20'd1;
        for (int i = 0; i < KW_MAX; i++)
            lx_word[i] = 8'd0;
        restart_source();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: paired colons, lone colon, leading underscore, high and control
        // bytes, a broken number, the plus/bar fixes, a newline, both end forms.
        queue_text("a::b:_");
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_text("1.2.3 +=+|;\n3.5");
        queue_byte(8'hFF, 1'b1);
        queue_text("int|");
        queue_byte(8'd0, 1'b0);

        // Settings: reset value, zero, saturating line count, random, back to one.
        line_setting = '{20'd1, 20'd0, SAT20, 20'($urandom_range(2, 1000000)), 20'd1};
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
                write_first_line(line_setting[ph]);
            if (ph == 2)
                queue_text("x\n\ny\n");
            // Fill the output queue behind a long receiver hold-off.
            holds_asked++;
            for (int i = 0; i < 60; i++)
                queue_random_lexeme();
            wait_idle();
        end

        while (token_expect_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("** source_byte_tokenizer: PASSED **");
        else
            $display("** source_byte_tokenizer: FAILED **");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("** source_byte_tokenizer: FAILED **");
        $finish;
    end

endmodule
